>>> design/dhsc_pkg.sv
`default_nettype none
package dhsc_pkg;

  // Default sizes of the slot table and of a probe set.
  localparam int TABLE_CAPACITY_DEF = 32768;
  localparam int MAX_SET_SIZE_DEF   = 16;

  // Field widths fixed by the interface.
  localparam int KEY_W   = 31;
  localparam int TSIZE_W = 16;
  localparam int PRIME_W = 15;
  localparam int SSIZE_W = 5;
  localparam int CFG_W   = 16;
  localparam int SLOT_W  = 15;
  localparam int COUNT_W = 5;

  // Remainder unit: 32-bit dividend, 16-bit divisor.
  localparam int DVD_W = 32;
  localparam int MOD_W = 16;

  // Configuration register indexes.
  localparam logic [1:0] REG_TABLE_SIZE = 2'd0;
  localparam logic [1:0] REG_STEP_PRIME = 2'd1;
  localparam logic [1:0] REG_SET_SIZE   = 2'd2;

  // Outcome codes.
  localparam logic [1:0] OUT_FILL = 2'd0;
  localparam logic [1:0] OUT_HIT  = 2'd1;
  localparam logic [1:0] OUT_REPL = 2'd2;
  localparam logic [1:0] OUT_SKIP = 2'd3;

  // Remainder operations, run in this order.
  localparam logic [2:0] OP_DEV_M  = 3'd0;
  localparam logic [2:0] OP_INO_M  = 3'd1;
  localparam logic [2:0] OP_HOME   = 3'd2;
  localparam logic [2:0] OP_DEV_P  = 3'd3;
  localparam logic [2:0] OP_INO_P  = 3'd4;
  localparam logic [2:0] OP_STEP   = 3'd5;
  localparam logic [2:0] OP_STEP_M = 3'd6;

  typedef struct packed {
    logic       clr_wr;
    logic       load_item;
    logic       mod_start;
    logic       mod_store;
    logic [2:0] op;
    logic       probe_init;
    logic       rd;
    logic       advance;
    logic       wr_fill;
    logic       wr_repl;
    logic       res_skip;
    logic       res_fill;
    logic       res_hit;
    logic       res_repl;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic mod_done;
    logic ino_zero;
    logic slot_empty;
    logic slot_hit;
    logic last_probe;
  } status_t;

endpackage
`default_nettype wire

>>> design/dhsc_mod.sv
`default_nettype none
module dhsc_mod (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [dhsc_pkg::DVD_W-1:0] dividend,
  input  wire logic [dhsc_pkg::MOD_W-1:0] divisor,
  output logic                           done,
  output logic [dhsc_pkg::MOD_W-1:0]     rem
);
  import dhsc_pkg::*;

  localparam int CW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [MOD_W:0]   trial;
  logic [MOD_W-1:0] rem_next;

  // One restoring step per cycle: shift in the next dividend bit.
  always_comb begin
    trial = {rem, dvd[DVD_W-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_next = MOD_W'(trial - {1'b0, divisor});
    end else begin
      rem_next = trial[MOD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[DVD_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

endmodule
`default_nettype wire

>>> design/dhsc_dp.sv
`default_nettype none
module dhsc_dp #(
  parameter int TABLE_CAPACITY = dhsc_pkg::TABLE_CAPACITY_DEF,
  parameter int MAX_SET_SIZE   = dhsc_pkg::MAX_SET_SIZE_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_write,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [dhsc_pkg::CFG_W-1:0]   cfg_data,
  input  wire logic [dhsc_pkg::KEY_W-1:0]   device_id,
  input  wire logic [dhsc_pkg::KEY_W-1:0]   inode_num,
  input  wire dhsc_pkg::cmd_t              cmd,
  output dhsc_pkg::status_t                status,
  output logic [1:0]                       outcome,
  output logic [dhsc_pkg::SLOT_W-1:0]      slot_index,
  output logic [dhsc_pkg::COUNT_W-1:0]     probe_count
);
  import dhsc_pkg::*;

  localparam int AW = $clog2(TABLE_CAPACITY);
  localparam int NW = $clog2(MAX_SET_SIZE + 1);

  logic [TSIZE_W-1:0] table_size;
  logic [PRIME_W-1:0] step_prime;
  logic [SSIZE_W-1:0] set_size;

  logic [MOD_W-1:0] m_eff;
  logic [MOD_W-1:0] p_eff;
  logic [NW-1:0]    n_eff;

  logic [KEY_W-1:0] dev;
  logic [KEY_W-1:0] ino;
  logic [MOD_W-1:0] a, b, c, d, home, step, step_m;
  logic [MOD_W-1:0] idx, victim;
  logic [NW-1:0]    cnt, vc, sel;
  logic [AW-1:0]    clr_addr;

  logic [DVD_W-1:0] mod_dvd;
  logic [MOD_W-1:0] mod_div;
  logic             mod_done;
  logic [MOD_W-1:0] mod_rem;
  logic [MOD_W:0]   idx_sum;
  logic [MOD_W-1:0] victim_addr;

  logic             mem_valid [TABLE_CAPACITY];
  logic [KEY_W-1:0] mem_dev   [TABLE_CAPACITY];
  logic [KEY_W-1:0] mem_ino   [TABLE_CAPACITY];
  logic             rd_valid;
  logic [KEY_W-1:0] rd_dev;
  logic [KEY_W-1:0] rd_ino;
  logic [AW-1:0]    wr_addr;

  logic [1:0]         res_outcome;
  logic [MOD_W-1:0]   res_slot;
  logic [COUNT_W-1:0] res_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= TSIZE_W'(29989);
      step_prime <= PRIME_W'(14983);
      set_size   <= SSIZE_W'(2);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TABLE_SIZE: table_size <= cfg_data;
        REG_STEP_PRIME: step_prime <= cfg_data[PRIME_W-1:0];
        REG_SET_SIZE:   set_size   <= cfg_data[SSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (table_size == '0) begin
      m_eff = MOD_W'(1);
    end else if (32'(table_size) > TABLE_CAPACITY) begin
      m_eff = MOD_W'(TABLE_CAPACITY);
    end else begin
      m_eff = table_size;
    end
    p_eff = (step_prime == '0) ? MOD_W'(1) : MOD_W'(step_prime);
    if (set_size == '0) begin
      n_eff = NW'(1);
    end else if (32'(set_size) > MAX_SET_SIZE) begin
      n_eff = NW'(MAX_SET_SIZE);
    end else begin
      n_eff = NW'(set_size);
    end
  end

  always_comb begin
    case (cmd.op)
      OP_DEV_M:  begin mod_dvd = DVD_W'(dev);  mod_div = m_eff; end
      OP_INO_M:  begin mod_dvd = DVD_W'(ino);  mod_div = m_eff; end
      OP_HOME:   begin mod_dvd = DVD_W'(a) * DVD_W'(b); mod_div = m_eff; end
      OP_DEV_P:  begin mod_dvd = DVD_W'(dev);  mod_div = p_eff; end
      OP_INO_P:  begin mod_dvd = DVD_W'(ino);  mod_div = p_eff; end
      OP_STEP:   begin mod_dvd = DVD_W'(c) * DVD_W'(d); mod_div = p_eff; end
      OP_STEP_M: begin mod_dvd = DVD_W'(step); mod_div = m_eff; end
      default:   begin mod_dvd = DVD_W'(dev);  mod_div = m_eff; end
    endcase
  end

  dhsc_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.mod_start),
    .dividend (mod_dvd),
    .divisor  (mod_div),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      dev <= device_id;
      ino <= inode_num;
    end
    if (cmd.mod_store) begin
      case (cmd.op)
        OP_DEV_M:  a      <= mod_rem;
        OP_INO_M:  b      <= mod_rem;
        OP_HOME:   home   <= mod_rem;
        OP_DEV_P:  c      <= mod_rem;
        OP_INO_P:  d      <= mod_rem;
        OP_STEP:   step   <= mod_rem + 1'b1;
        OP_STEP_M: step_m <= mod_rem;
        default: ;
      endcase
    end
  end

  assign idx_sum     = {1'b0, idx} + {1'b0, step_m};
  assign sel         = (vc < n_eff) ? vc : '0;
  assign victim_addr = (cnt == sel) ? idx : victim;

  always_ff @(posedge clk) begin
    if (cmd.probe_init) begin
      idx <= home;
      cnt <= '0;
    end else if (cmd.advance) begin
      if (cnt == sel) begin
        victim <= idx;
      end
      idx <= (idx_sum >= {1'b0, m_eff}) ? MOD_W'(idx_sum - {1'b0, m_eff})
                                        : idx_sum[MOD_W-1:0];
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc       <= '0;
      clr_addr <= '0;
    end else begin
      if (cmd.clr_wr) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.wr_repl) begin
        vc <= (({1'b0, sel} + 1'b1) >= {1'b0, n_eff}) ? '0 : sel + 1'b1;
      end
    end
  end

  assign wr_addr = cmd.clr_wr  ? clr_addr :
                   cmd.wr_repl ? AW'(victim_addr) : AW'(idx);

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem_valid[wr_addr] <= 1'b0;
    end else if (cmd.wr_fill || cmd.wr_repl) begin
      mem_valid[wr_addr] <= 1'b1;
      mem_dev[wr_addr]   <= dev;
      mem_ino[wr_addr]   <= ino;
    end
    if (cmd.rd) begin
      rd_valid <= mem_valid[AW'(idx)];
      rd_dev   <= mem_dev[AW'(idx)];
      rd_ino   <= mem_ino[AW'(idx)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_skip) begin
      res_outcome <= OUT_SKIP;
      res_slot    <= '0;
      res_cnt     <= '0;
    end else if (cmd.res_fill || cmd.res_hit) begin
      res_outcome <= cmd.res_fill ? OUT_FILL : OUT_HIT;
      res_slot    <= idx;
      res_cnt     <= COUNT_W'(cnt + 1'b1);
    end else if (cmd.res_repl) begin
      res_outcome <= OUT_REPL;
      res_slot    <= victim_addr;
      res_cnt     <= COUNT_W'(n_eff);
    end
    if (cmd.out_load) begin
      outcome     <= res_outcome;
      slot_index  <= SLOT_W'(res_slot);
      probe_count <= res_cnt;
    end
  end

  always_comb begin
    status.clr_last   = (clr_addr == AW'(TABLE_CAPACITY - 1));
    status.mod_done   = mod_done;
    status.ino_zero   = (inode_num == '0);
    status.slot_empty = !rd_valid;
    status.slot_hit   = rd_valid && (rd_dev == dev) && (rd_ino == ino);
    status.last_probe = (({1'b0, cnt} + 1'b1) == {1'b0, n_eff});
  end

endmodule
`default_nettype wire

>>> design/dhsc_ctrl.sv
`default_nettype none
module dhsc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire dhsc_pkg::status_t status,
  output dhsc_pkg::cmd_t         cmd
);
  import dhsc_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_MSTART = 3'd2;
  localparam logic [2:0] S_MWAIT  = 3'd3;
  localparam logic [2:0] S_RD     = 3'd4;
  localparam logic [2:0] S_CMP    = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state, state_next;
  logic [2:0] op, op_next;
  logic       out_valid_next;

  always_comb begin
    state_next = state;
    op_next    = op;
    cmd        = '0;
    cmd.op     = op;
    in_stall   = (state != S_IDLE);
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (status.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          if (status.ino_zero) begin
            cmd.res_skip = 1'b1;
            state_next   = S_DONE;
          end else begin
            op_next    = OP_DEV_M;
            state_next = S_MSTART;
          end
        end
      end
      S_MSTART: begin
        cmd.mod_start = 1'b1;
        state_next    = S_MWAIT;
      end
      S_MWAIT: begin
        if (status.mod_done) begin
          cmd.mod_store = 1'b1;
          if (op == OP_STEP_M) begin
            cmd.probe_init = 1'b1;
            state_next     = S_RD;
          end else begin
            op_next    = op + 1'b1;
            state_next = S_MSTART;
          end
        end
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (status.slot_empty) begin
          cmd.wr_fill  = 1'b1;
          cmd.res_fill = 1'b1;
          state_next   = S_DONE;
        end else if (status.slot_hit) begin
          cmd.res_hit = 1'b1;
          state_next  = S_DONE;
        end else if (status.last_probe) begin
          cmd.wr_repl  = 1'b1;
          cmd.res_repl = 1'b1;
          state_next   = S_DONE;
        end else begin
          cmd.advance = 1'b1;
          state_next  = S_RD;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      op        <= OP_DEV_M;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      op        <= op_next;
      out_valid <= out_valid_next;
    end
  end

  a_cmp_after_rd: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP |-> $past(state) == S_RD)
    else $error("compare step without a preceding read");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result loaded over an untaken beat");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    status.mod_done |-> state == S_MWAIT)
    else $error("remainder finished outside its wait state");

  a_one_write: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.clr_wr, cmd.wr_fill, cmd.wr_repl}) <= 1)
    else $error("two table writes in one cycle");

endmodule
`default_nettype wire

>>> design/double_hash_set_cache_core.sv
`default_nettype none
// Channel   Handshake                    Beat contents
// config    cfg_write                    cfg_index, cfg_data
// input     in_valid / in_stall          device_id, inode_num
// output    out_valid / out_stall        outcome, slot_index, probe_count
//
// One key is handled at a time. A key runs seven remainder operations on one
// shared unit that retires one dividend bit per cycle, then reads and compares
// the probed slots of the table in turn, up to the set size; a key with inode
// zero skips both and goes straight to its result.
// After reset the table is swept once to mark every slot empty; input is
// stalled during the sweep while configuration writes are taken. A finished
// result sits in the output register while the next key is accepted;
// out_stall holds that result, and a later result waits until it is taken.
module double_hash_set_cache_core #(
  parameter int TABLE_CAPACITY = dhsc_pkg::TABLE_CAPACITY_DEF,
  parameter int MAX_SET_SIZE   = dhsc_pkg::MAX_SET_SIZE_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_write,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [dhsc_pkg::CFG_W-1:0]  cfg_data,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [dhsc_pkg::KEY_W-1:0]  device_id,
  input  wire logic [dhsc_pkg::KEY_W-1:0]  inode_num,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [1:0]                      outcome,
  output logic [dhsc_pkg::SLOT_W-1:0]     slot_index,
  output logic [dhsc_pkg::COUNT_W-1:0]    probe_count
);
  import dhsc_pkg::*;

  cmd_t    cmd;
  status_t status;

  // The sequencer steps through clear, hash, probe and result phases.
  dhsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds configuration, hash registers, the slot table and
  // the result registers.
  dhsc_dp #(
    .TABLE_CAPACITY (TABLE_CAPACITY),
    .MAX_SET_SIZE   (MAX_SET_SIZE)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .device_id   (device_id),
    .inode_num   (inode_num),
    .cmd         (cmd),
    .status      (status),
    .outcome     (outcome),
    .slot_index  (slot_index),
    .probe_count (probe_count)
  );

endmodule
`default_nettype wire

>>> verif/tb_double_hash_set_cache_core.sv
`default_nettype none
module tb_double_hash_set_cache_core;
  timeunit 1ns;
  timeprecision 1ps;
  import dhsc_pkg::*;

  localparam int CAPACITY    = TABLE_CAPACITY_DEF;
  localparam int SET_MAX     = MAX_SET_SIZE_DEF;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int PHASE_KEYS  = 195;
  localparam int LONG_HOLD   = 3000;

  typedef struct {
    logic [1:0]         outcome;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] probes;
  } lookup_t;

  typedef struct {
    logic [KEY_W-1:0] dev;
    logic [KEY_W-1:0] ino;
    bit               known;
    lookup_t          res;
  } key_row_t;

  typedef struct {
    logic [TSIZE_W-1:0] tsize;
    logic [PRIME_W-1:0] prime;
    logic [SSIZE_W-1:0] ways;
  } setting_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = REG_TABLE_SIZE;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [KEY_W-1:0] device_id = '0;
  logic [KEY_W-1:0] inode_num = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] outcome;
  logic [SLOT_W-1:0] slot_index;
  logic [COUNT_W-1:0] probe_count;

  always #1 clk = ~clk;

  double_hash_set_cache_core u_top (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .device_id, .inode_num,
    .out_valid, .out_stall, .outcome, .slot_index, .probe_count
  );

  // Shadow copy of the slot table and of the three registers. The stored key
  // is consulted only where the valid bit is set, as in the block.
  bit               shadow_used[CAPACITY];
  logic [KEY_W-1:0] shadow_dev[CAPACITY];
  logic [KEY_W-1:0] shadow_ino[CAPACITY];
  int unsigned      victim_ptr;
  logic [TSIZE_W-1:0] cur_tsize = 16'd29989;
  logic [PRIME_W-1:0] cur_prime = 15'd14983;
  logic [SSIZE_W-1:0] cur_ways  = 5'd2;

  lookup_t pending_lookups[$];
  logic [2*KEY_W-1:0] recent_keys[$];
  int fails = 0;
  int keys_sent = 0;
  int seen_fill = 0, seen_hit = 0, seen_repl = 0, seen_skip = 0;
  longint cycles = 0;
  bit quiet = 1'b0;        // no idling on either side while set
  bit hold_request = 1'b0; // asks the receiver for one long hold-off

  // Looks a key up in the shadow table, updates it, and returns the beat that
  // the block should report. Out-of-range registers are clamped the way the
  // block clamps them.
  function automatic lookup_t lookup_key(logic [KEY_W-1:0] dev, logic [KEY_W-1:0] ino);
    lookup_t r;
    longint unsigned m, p, home, step, idx;
    int unsigned n, sel;
    r = '{OUT_SKIP, '0, '0};
    if (ino == '0) return r;
    m = (cur_tsize == 0) ? 1 : (cur_tsize > CAPACITY) ? CAPACITY : cur_tsize;
    p = (cur_prime == 0) ? 1 : cur_prime;
    n = (cur_ways == 0) ? 1 : (cur_ways > SET_MAX) ? SET_MAX : cur_ways;
    home = ((dev % m) * (ino % m)) % m;
    step = ((dev % p) * (ino % p)) % p + 1;
    idx = home;
    for (int c = 0; c < n; c++) begin
      if (!shadow_used[idx]) begin
        shadow_used[idx] = 1'b1;
        shadow_dev[idx] = dev;
        shadow_ino[idx] = ino;
        return '{OUT_FILL, SLOT_W'(idx), COUNT_W'(c + 1)};
      end
      if (shadow_dev[idx] == dev && shadow_ino[idx] == ino)
        return '{OUT_HIT, SLOT_W'(idx), COUNT_W'(c + 1)};
      idx = (idx + step) % m;
    end
    // Every probed slot holds another key: evict round robin. A pointer left
    // at or above the set size by a lowered register falls back to the first way.
    sel = (victim_ptr < n) ? victim_ptr : 0;
    victim_ptr = (sel + 1 >= n) ? 0 : sel + 1;
    idx = (home + longint'(sel) * step) % m;
    shadow_used[idx] = 1'b1;
    shadow_dev[idx] = dev;
    shadow_ino[idx] = ino;
    return '{OUT_REPL, SLOT_W'(idx), COUNT_W'(n)};
  endfunction

  // Offers one key after a random gap, none while quiet, and waits for the beat to be taken.
  // The lookup is predicted at the accepting edge, so the table order matches
  // the order in which the block sees the keys.
  task automatic offer_key(logic [KEY_W-1:0] dev, logic [KEY_W-1:0] ino,
                           bit known, lookup_t typed);
    int gap;
    lookup_t r;
    gap = quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    device_id <= dev;
    inode_num <= ino;
    do @(posedge clk); while (in_stall);
    r = lookup_key(dev, ino);
    pending_lookups.push_back(known ? typed : r);
    recent_keys.push_back({dev, ino});
    if (recent_keys.size() > 24) void'(recent_keys.pop_front());
    keys_sent++;
  endtask

  task automatic write_reg(logic [1:0] index, logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    case (index)
      REG_TABLE_SIZE: cur_tsize = value[TSIZE_W-1:0];
      REG_STEP_PRIME: cur_prime = value[PRIME_W-1:0];
      REG_SET_SIZE:   cur_ways  = value[SSIZE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Receiver: every result beat is checked against the oldest expectation.
  // Between beats it stalls for a random count of cycles unless quiet is set,
  // and once for a long stretch so that the output register fills and the input backs up.
  initial begin
    int hold;
    lookup_t e;
    hold = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        case (outcome)
          OUT_FILL: seen_fill++;
          OUT_HIT:  seen_hit++;
          OUT_REPL: seen_repl++;
          default:  seen_skip++;
        endcase
        if (pending_lookups.size() == 0) begin
          $display("%0t: result beat with nothing expected: outcome %0d slot %0d probes %0d",
                   $realtime, outcome, slot_index, probe_count);
          fails++;
        end else begin
          e = pending_lookups.pop_front();
          if (outcome !== e.outcome) begin
            $display("%0t: outcome expected %0d actual %0d", $realtime, e.outcome, outcome);
            fails++;
          end
          if (slot_index !== e.slot) begin
            $display("%0t: slot_index expected %0d actual %0d", $realtime, e.slot, slot_index);
            fails++;
          end
          if (probe_count !== e.probes) begin
            $display("%0t: probe_count expected %0d actual %0d",
                     $realtime, e.probes, probe_count);
            fails++;
          end
        end
        hold = quiet ? 0 : $urandom_range(0, 17);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold = LONG_HOLD;
      end
      if (hold > 0) hold--;
      out_stall <= (hold > 0);
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycles, pending_lookups.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    key_row_t rows[$];
    setting_t settings[$];
    logic [2*KEY_W-1:0] pick;
    logic [KEY_W-1:0] dev, ino;
    int sel;

    for (int i = 0; i < CAPACITY; i++) shadow_used[i] = 1'b0;
    victim_ptr = 0;

    // Directed keys under the reset settings. With device zero the home slot
    // is 0 and the step is 1, so the first rows can be read off by hand:
    // skipped keys, a fill, a hit, a fill at the second probe, two evictions
    // in round-robin order and a hit at the second probe.
    rows = '{
      '{31'd0, 31'd0, 1'b1, '{OUT_SKIP, 15'd0, 5'd0}},
      '{31'h7fffffff, 31'd0, 1'b1, '{OUT_SKIP, 15'd0, 5'd0}},
      '{31'd0, 31'd5, 1'b1, '{OUT_FILL, 15'd0, 5'd1}},
      '{31'd0, 31'd5, 1'b1, '{OUT_HIT, 15'd0, 5'd1}},
      '{31'd0, 31'd7, 1'b1, '{OUT_FILL, 15'd1, 5'd2}},
      '{31'd0, 31'd9, 1'b1, '{OUT_REPL, 15'd0, 5'd2}},
      '{31'd0, 31'd11, 1'b1, '{OUT_REPL, 15'd1, 5'd2}},
      '{31'd0, 31'd11, 1'b1, '{OUT_HIT, 15'd1, 5'd2}},
      '{31'h7fffffff, 31'h7fffffff, 1'b0, '{OUT_SKIP, 15'd0, 5'd0}},
      '{31'h7fffffff, 31'h7fffffff, 1'b0, '{OUT_SKIP, 15'd0, 5'd0}},
      '{31'd1, 31'd1, 1'b0, '{OUT_SKIP, 15'd0, 5'd0}},
      '{31'h55555555, 31'h2aaaaaaa, 1'b0, '{OUT_SKIP, 15'd0, 5'd0}},
      '{31'h2aaaaaaa, 31'h55555555, 1'b0, '{OUT_SKIP, 15'd0, 5'd0}},
      '{31'h40000000, 31'd1, 1'b0, '{OUT_SKIP, 15'd0, 5'd0}},
      '{31'd1, 31'h40000000, 1'b0, '{OUT_SKIP, 15'd0, 5'd0}}
    };

    // Register settings for the random phases. Zero and all-ones values check
    // the clamping; tiny tables with wide sets force evictions, and lowering
    // the set size after a wide one can leave the victim pointer out of range.
    settings = '{
      '{16'd5, 15'd2, 5'd1},      '{16'd7, 15'd3, 5'd16},
      '{16'd0, 15'd0, 5'd0},      '{16'd11, 15'd7, 5'd3},
      '{16'd65535, 15'd32767, 5'd31}, '{16'd13, 15'd5, 5'd16},
      '{16'd32768, 15'd2, 5'd17}, '{16'd97, 15'd89, 5'd8},
      '{16'd1, 15'd1, 5'd4},      '{16'd29989, 15'd14983, 5'd2}
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) offer_key(rows[i].dev, rows[i].ino, rows[i].known, rows[i].res);

    foreach (settings[ph]) begin
      // The last key must not be offered again while the block drains.
      in_valid <= 1'b0;
      wait_idle();
      write_reg(REG_TABLE_SIZE, CFG_W'(settings[ph].tsize));
      write_reg(REG_STEP_PRIME, CFG_W'(settings[ph].prime));
      write_reg(REG_SET_SIZE, CFG_W'(settings[ph].ways));
      @(posedge clk);
      cfg_write <= 1'b0;
      quiet = (ph % 3 == 2);
      if (ph == 1) hold_request = 1'b1;
      for (int k = 0; k < PHASE_KEYS; k++) begin
        sel = $urandom_range(0, 99);
        if (sel < 40 && recent_keys.size() > 0) begin
          // Reuse a recent key so that hits are common.
          pick = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
          dev = pick[2*KEY_W-1:KEY_W];
          ino = pick[KEY_W-1:0];
        end else begin
          dev = KEY_W'($urandom());
          ino = KEY_W'($urandom());
          if (sel < 70) begin
            // Small keys crowd the low slots.
            dev = dev % 64;
            ino = ino % 64;
          end
          if (sel >= 95) ino = '0;
        end
        offer_key(dev, ino, 1'b0, '{OUT_SKIP, '0, '0});
      end
    end

    in_valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Sent %0d keys over %0d register settings.", keys_sent, settings.size() + 1);
    $display("Seen %0d fills, %0d hits, %0d evictions, %0d skips; %0d mismatches.",
             seen_fill, seen_hit, seen_repl, seen_skip, fails);
    if (fails == 0 && pending_lookups.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> double_hash_set_cache_core.f
design/dhsc_pkg.sv
design/dhsc_mod.sv
design/dhsc_dp.sv
design/dhsc_ctrl.sv
design/double_hash_set_cache_core.sv
verif/tb_double_hash_set_cache_core.sv
